// File: rtl/core/npb_pkg.sv
package npb_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 18;
    localparam int NUM_AXES       = 3;

    localparam int SLOT_W    = 10;
    localparam int VID_W     = 16;
    localparam int THR_W     = 38;
    localparam int CFG_CNT_W = 11;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POINT_COUNT = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // tag that rides along with each point through the cell chain
    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

endpackage

// File: rtl/core/npb_ram.sv
module npb_ram #(
    parameter int WIDTH = 54,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_wen,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/npb_axis_cell.sv
module npb_axis_cell import npb_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int AXIS       = 0,
    parameter int AW         = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_ctl                               i_ctl,
    input  logic [AW-1:0]                      i_idx,
    input  logic [NUM_AXES*COORD_BITS-1:0]     i_point,
    input  logic [NUM_AXES*COORD_BITS-1:0]     i_query,
    input  logic [2*COORD_BITS+1:0]            i_sum,
    output t_ctl                               o_ctl,
    output logic [AW-1:0]                      o_idx,
    output logic [NUM_AXES*COORD_BITS-1:0]     o_point,
    output logic [2*COORD_BITS+1:0]            o_sum
);

    localparam int CB = COORD_BITS;
    localparam int PW = NUM_AXES * CB;
    localparam int DW = 2 * CB + 2;

    logic [CB-1:0]        w_p;
    logic [CB-1:0]        w_q;
    logic signed [CB:0]   w_diff;
    logic signed [DW-1:0] w_sq;

    t_ctl                 r_a_ctl;
    logic [AW-1:0]        r_a_idx;
    logic [PW-1:0]        r_a_point;
    logic [DW-1:0]        r_a_sum;
    logic signed [CB:0]   r_a_diff;

    t_ctl                 r_b_ctl;
    logic [AW-1:0]        r_b_idx;
    logic [PW-1:0]        r_b_point;
    logic [DW-1:0]        r_b_sum;

    assign w_p    = i_point[AXIS*CB +: CB];
    assign w_q    = i_query[AXIS*CB +: CB];
    assign w_diff = $signed({w_q[CB-1], w_q}) - $signed({w_p[CB-1], w_p});
    assign w_sq   = r_a_diff * r_a_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_idx   <= i_idx;
        r_a_point <= i_point;
        r_a_sum   <= i_sum;
        r_a_diff  <= w_diff;
        r_b_idx   <= r_a_idx;
        r_b_point <= r_a_point;
        // square of a difference is never negative
        r_b_sum   <= r_a_sum + DW'($unsigned(w_sq));
    end

    assign o_ctl   = r_b_ctl;
    assign o_idx   = r_b_idx;
    assign o_point = r_b_point;
    assign o_sum   = r_b_sum;

endmodule

// File: rtl/core/npb_best_cell.sv
module npb_best_cell import npb_pkg::*; #(
    parameter int AW = 10,
    parameter int DW = 38
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  t_ctl             i_ctl,
    input  logic [AW-1:0]    i_idx,
    input  logic [DW-1:0]    i_dist,
    input  logic [THR_W-1:0] i_thr,
    output logic             o_fin,
    output logic             o_hit,
    output logic [AW-1:0]    o_idx
);

    localparam int MW = (DW > THR_W) ? DW : THR_W;

    logic          r_found;
    logic          r_fin;
    logic [DW-1:0] r_best_d;
    logic [AW-1:0] r_best_i;
    logic          w_better;

    // strict compare keeps the lowest index on a tie
    assign w_better = !r_found || (i_dist < r_best_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_fin   <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
            r_fin   <= 1'b0;
        end else if (i_ctl.valid) begin
            r_found <= 1'b1;
            r_fin   <= i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid && w_better) begin
            r_best_d <= i_dist;
            r_best_i <= i_idx;
        end
    end

    assign o_fin = r_fin;
    assign o_hit = r_found && (MW'(r_best_d) < MW'(i_thr));
    assign o_idx = r_best_i;

endmodule

// File: rtl/core/nearest_point_bond_search.sv
// Nearest reference point search. A load item (tuser 0) writes one point into the point
// store; loads to slots at or above MAX_POINTS are dropped. A query item (tuser 1) reads
// the first point_count stored points (saturated to MAX_POINTS) one per cycle from the
// store's read port and sends them down a chain of three axis cells, each adding one
// squared coordinate difference, into a cell that keeps the running minimum (lowest index
// on a tie). With point_count 0 a query gives nothing. A bond item (vertex id, point
// index) comes out only when the minimum squared distance is strictly below
// threshold_squared. Points that a query reads must have been loaded first. The output
// register lets the next item in while a bond item waits.
module nearest_point_bond_search import npb_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // slot, vertex_id, coord_x, coord_y, coord_z, zero pad
    input  logic [((SLOT_W+VID_W+NUM_AXES*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // opcode
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // bond_vertex, bond_point, zero pad
    output logic [((VID_W+SLOT_W+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW     = ($clog2(MAX_POINTS + 1) > CFG_CNT_W) ?
                            $clog2(MAX_POINTS + 1) : CFG_CNT_W;
    localparam int IW     = (AW > SLOT_W) ? AW : SLOT_W;
    localparam int PW     = NUM_AXES * COORD_BITS;
    localparam int DW     = 2 * COORD_BITS + 2;
    localparam int OUT_W  = ((VID_W + SLOT_W + 7) / 8) * 8;

    t_state                r_state;
    t_state                n_state;

    logic [THR_W-1:0]      r_cfg_thr;
    logic [CFG_CNT_W-1:0]  r_cfg_count;

    logic [SLOT_W-1:0]     w_in_slot;
    logic [VID_W-1:0]      w_in_vid;
    logic [PW-1:0]         w_in_point;
    logic [IW-1:0]         w_slot_ext;
    logic                  w_in_acc;
    logic                  w_load;
    logic                  w_query;
    logic                  w_wr_en;

    logic [CW-1:0]         w_cnt_ext;
    logic [CW-1:0]         w_cnt_sat;
    logic [CW-1:0]         w_cnt_m1;

    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_last_idx;
    logic [AW-1:0]         r_idx;
    logic [VID_W-1:0]      r_vid;
    logic [PW-1:0]         r_query;

    logic                  w_issue;
    logic                  w_issue_last;
    logic [PW-1:0]         w_rd_data;
    t_ctl                  r_rd_ctl;
    logic [AW-1:0]         r_rd_idx;

    t_ctl                  w_ctl [0:NUM_AXES];
    logic [AW-1:0]         w_idx [0:NUM_AXES];
    logic [PW-1:0]         w_pt  [0:NUM_AXES-1];
    logic [DW-1:0]         w_sum [0:NUM_AXES];

    logic                  w_fin;
    logic                  w_hit;
    logic [AW-1:0]         w_best_idx;
    logic [IW-1:0]         w_best_ext;

    logic                  w_out_free;
    logic                  w_out_load;
    logic                  r_out_valid;
    logic [VID_W-1:0]      r_out_vertex;
    logic [SLOT_W-1:0]     r_out_point;

    // input fields
    assign w_in_slot  = i_s_axis_tdata[SLOT_W-1:0];
    assign w_in_vid   = i_s_axis_tdata[SLOT_W+VID_W-1:SLOT_W];
    assign w_in_point = i_s_axis_tdata[SLOT_W+VID_W+PW-1:SLOT_W+VID_W];
    assign w_slot_ext = IW'(w_in_slot);

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load   = w_in_acc && (i_s_axis_tuser == OP_LOAD);
    assign w_query  = w_in_acc && (i_s_axis_tuser == OP_QUERY);
    assign w_wr_en  = w_load && (32'(w_in_slot) < 32'(MAX_POINTS));

    assign w_cnt_ext = CW'(r_cfg_count);
    assign w_cnt_sat = (w_cnt_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : w_cnt_ext;
    assign w_cnt_m1  = w_cnt_sat - CW'(1);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_thr   <= '0;
            r_cfg_count <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                CFG_THRESHOLD: begin
                    r_cfg_thr <= i_cfg_wdata[THR_W-1:0];
                end
                CFG_POINT_COUNT: begin
                    r_cfg_count <= i_cfg_wdata[CFG_CNT_W-1:0];
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_query && (w_cnt_sat != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_last_idx) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_fin && w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_issue         = 1'b0;
        w_out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            ST_SCAN: begin
                w_issue = 1'b1;
            end
            ST_DRAIN: begin
                w_out_load = w_fin && w_out_free && w_hit;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    assign w_issue_last = w_issue && (r_idx == r_last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_rd_ctl <= '0;
        end else begin
            r_state        <= n_state;
            r_rd_ctl.valid <= w_issue;
            r_rd_ctl.last  <= w_issue_last;
            if (w_query) begin
                r_idx <= '0;
            end else if (w_issue) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (w_query) begin
            r_count    <= w_cnt_sat;
            r_last_idx <= w_cnt_m1[AW-1:0];
            r_vid      <= w_in_vid;
            r_query    <= w_in_point;
        end
    end

    npb_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_wen   (w_wr_en),
        .i_waddr (w_slot_ext[AW-1:0]),
        .i_wdata (w_in_point),
        .i_raddr (r_idx),
        .o_rdata (w_rd_data)
    );

    assign w_ctl[0] = r_rd_ctl;
    assign w_idx[0] = r_rd_idx;
    assign w_pt[0]  = w_rd_data;
    assign w_sum[0] = '0;

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_cell
        if (k < NUM_AXES - 1) begin : g_mid
            npb_axis_cell #(
                .COORD_BITS (COORD_BITS),
                .AXIS       (k),
                .AW         (AW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[k]),
                .i_idx   (w_idx[k]),
                .i_point (w_pt[k]),
                .i_query (r_query),
                .i_sum   (w_sum[k]),
                .o_ctl   (w_ctl[k+1]),
                .o_idx   (w_idx[k+1]),
                .o_point (w_pt[k+1]),
                .o_sum   (w_sum[k+1])
            );
        end else begin : g_end
            npb_axis_cell #(
                .COORD_BITS (COORD_BITS),
                .AXIS       (k),
                .AW         (AW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[k]),
                .i_idx   (w_idx[k]),
                .i_point (w_pt[k]),
                .i_query (r_query),
                .i_sum   (w_sum[k]),
                .o_ctl   (w_ctl[k+1]),
                .o_idx   (w_idx[k+1]),
                .o_point (),
                .o_sum   (w_sum[k+1])
            );
        end
    end

    npb_best_cell #(
        .AW (AW),
        .DW (DW)
    ) u_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_query),
        .i_ctl   (w_ctl[NUM_AXES]),
        .i_idx   (w_idx[NUM_AXES]),
        .i_dist  (w_sum[NUM_AXES]),
        .i_thr   (r_cfg_thr),
        .o_fin   (w_fin),
        .o_hit   (w_hit),
        .o_idx   (w_best_idx)
    );

    assign w_best_ext = IW'(w_best_idx);

    // output register
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_vertex <= r_vid;
            r_out_point  <= w_best_ext[SLOT_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_point, r_out_vertex});

    a_no_fin_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !w_fin)
        else $error("minimum finished while points still being issued");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_count != '0))
        else $error("scan started with no points");

    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DRAIN) && w_fin) |-> (CW'(w_best_idx) < r_count))
        else $error("nearest point index beyond searched count");

    a_out_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == ST_DRAIN))
        else $error("bond item loaded outside drain state");

endmodule
